>>> src/qte_pkg.sv
`timescale 1ns / 1ps
package qte_pkg;

   // Field widths
   localparam int POS_W  = 32;
   localparam int QUAT_W = 16;
   localparam int ANG_OUT_W = 16;

   // Quaternion sums at scale 2^30 (products of Q1.15 parts, doubled)
   localparam int SUM_W  = 34;
   localparam int S_W    = 32;
   localparam int PROD_W = 32;

   // Square root operand and root
   localparam int RAD_W  = 61;
   localparam int ROOT_W = 31;
   localparam int ISQ_W  = 62;

   // CORDIC datapath
   localparam int DATA_W = 46;
   localparam int ACC_W  = 27;
   localparam int CORDIC_STAGES = 20;
   localparam int ROUND_LSB = 9;

   // Pipeline depths
   localparam int PROD_LAT   = 5;
   localparam int ISQ_LAT    = 31;
   localparam int CORDIC_LAT = CORDIC_STAGES + 2;
   localparam int TOTAL_LAT  = PROD_LAT + ISQ_LAT + CORDIC_LAT;

   localparam logic signed [SUM_W-1:0] ONE_Q30 = SUM_W'(64'sd1073741824);
   localparam logic signed [ACC_W-1:0] QUARTER_TURN = ACC_W'(32'sd8388608);
   localparam logic signed [ANG_OUT_W-1:0] ANG_HALF_TURN  = 16'sh8000;
   localparam logic signed [ANG_OUT_W-1:0] ANG_QUARTER_P  = 16'sd16384;
   localparam logic signed [ANG_OUT_W-1:0] ANG_QUARTER_N  = -16'sd16384;

   // Data that travels beside the square root
   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [SUM_W-1:0] ax_y;
      logic signed [SUM_W-1:0] ax_x;
      logic signed [SUM_W-1:0] az_y;
      logic signed [SUM_W-1:0] az_x;
      logic signed [S_W-1:0]   s;
   } side_type;

   // atan(2^-i) in units of pi/2^24
   function automatic logic signed [ACC_W-1:0] atan_entry(input logic [4:0] idx);
      logic signed [ACC_W-1:0] val;
      case (idx)
         5'd0:    val = 27'sd4194304;
         5'd1:    val = 27'sd2476042;
         5'd2:    val = 27'sd1308273;
         5'd3:    val = 27'sd664100;
         5'd4:    val = 27'sd333339;
         5'd5:    val = 27'sd166832;
         5'd6:    val = 27'sd83436;
         5'd7:    val = 27'sd41721;
         5'd8:    val = 27'sd20861;
         5'd9:    val = 27'sd10430;
         5'd10:   val = 27'sd5215;
         5'd11:   val = 27'sd2608;
         5'd12:   val = 27'sd1304;
         5'd13:   val = 27'sd652;
         5'd14:   val = 27'sd326;
         5'd15:   val = 27'sd163;
         5'd16:   val = 27'sd81;
         5'd17:   val = 27'sd41;
         5'd18:   val = 27'sd20;
         5'd19:   val = 27'sd10;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> src/qte_prod.sv
`timescale 1ns / 1ps
module qte_prod
   import qte_pkg::*;
(
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [POS_W-1:0]  pos_x,
   input  logic signed [POS_W-1:0]  pos_y,
   input  logic signed [POS_W-1:0]  pos_z,
   input  logic signed [QUAT_W-1:0] qx,
   input  logic signed [QUAT_W-1:0] qy,
   input  logic signed [QUAT_W-1:0] qz,
   input  logic signed [QUAT_W-1:0] qw,
   output side_type                 side,
   output logic [RAD_W-1:0]         radicand
);

   // Stage 1: pairwise products
   logic signed [POS_W-1:0]  px_ff, py_ff, pz_ff;
   logic signed [PROD_W-1:0] xx_ff, yy_ff, zz_ff, ww_ff, yz_ff, xw_ff;
   logic signed [PROD_W-1:0] xy_ff, zw_ff, xz_ff, yw_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= pos_x;
         py_ff <= pos_y;
         pz_ff <= pos_z;
         xx_ff <= qx * qx;
         yy_ff <= qy * qy;
         zz_ff <= qz * qz;
         ww_ff <= qw * qw;
         yz_ff <= qy * qz;
         xw_ff <= qx * qw;
         xy_ff <= qx * qy;
         zw_ff <= qz * qw;
         xz_ff <= qx * qz;
         yw_ff <= qy * qw;
      end
   end

   // Stage 2: sums for the three angles
   side_type side2_in, side2_ff;
   logic signed [SUM_W-1:0] s_raw_in, s_raw_ff;

   always_comb begin
      side2_in       = '0;
      side2_in.pos_x = px_ff;
      side2_in.pos_y = py_ff;
      side2_in.pos_z = pz_ff;
      side2_in.ax_y  = (SUM_W'(yz_ff) + SUM_W'(xw_ff)) <<< 1;
      side2_in.ax_x  = SUM_W'(ww_ff) - SUM_W'(xx_ff) - SUM_W'(yy_ff) + SUM_W'(zz_ff);
      side2_in.az_y  = (SUM_W'(xy_ff) + SUM_W'(zw_ff)) <<< 1;
      side2_in.az_x  = SUM_W'(ww_ff) + SUM_W'(xx_ff) - SUM_W'(yy_ff) - SUM_W'(zz_ff);
      s_raw_in       = (SUM_W'(yw_ff) - SUM_W'(xz_ff)) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side2_ff <= side2_in;
         s_raw_ff <= s_raw_in;
      end
   end

   // Stage 3: clamp the asin argument to +-1
   side_type side3_in, side3_ff;

   always_comb begin
      side3_in = side2_ff;
      if (s_raw_ff > ONE_Q30) begin
         side3_in.s = S_W'(ONE_Q30);
      end else if (s_raw_ff < -ONE_Q30) begin
         side3_in.s = S_W'(-ONE_Q30);
      end else begin
         side3_in.s = S_W'(s_raw_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side3_ff <= side3_in;
      end
   end

   // Stage 4: square of the argument
   logic signed [2*S_W-1:0] sq_full;
   logic [RAD_W-1:0] sq_ff;
   side_type side4_ff;

   assign sq_full = side3_ff.s * side3_ff.s;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff    <= sq_full[RAD_W-1:0];
         side4_ff <= side3_ff;
      end
   end

   // Stage 5: 1 - s^2 at scale 2^60
   logic [RAD_W-1:0] rad_in, rad_ff;
   side_type side5_ff;

   assign rad_in = (RAD_W'(1) << (RAD_W - 1)) - sq_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff   <= rad_in;
         side5_ff <= side4_ff;
      end
   end

   assign side     = side5_ff;
   assign radicand = rad_ff;

endmodule

>>> src/qte_isqrt.sv
`timescale 1ns / 1ps
module qte_isqrt
   import qte_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [RAD_W-1:0]  radicand,
   output logic [ROOT_W-1:0] root
);

   // One result bit per stage, bit weight 4^(30-k)
   logic [ISQ_W-1:0] rem_ff [ISQ_LAT];
   logic [ISQ_W-1:0] res_ff [ISQ_LAT];

   for (genvar k = 0; k < ISQ_LAT; k++) begin : g_stage
      logic [ISQ_W-1:0] rem_prev, res_prev, trial, rem_in, res_in;
      localparam logic [ISQ_W-1:0] BIT_W = ISQ_W'(1) << (2 * (ISQ_LAT - 1 - k));

      if (k == 0) begin : g_first
         assign rem_prev = ISQ_W'(radicand);
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign res_prev = res_ff[k-1];
      end

      always_comb begin
         trial = res_prev + BIT_W;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) + BIT_W;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            res_ff[k] <= res_in;
         end
      end
   end

   assign root = res_ff[ISQ_LAT-1][ROOT_W-1:0];

endmodule

>>> src/qte_cordic.sv
`timescale 1ns / 1ps
module qte_cordic
   import qte_pkg::*;
(
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [SUM_W-1:0]     y_in,
   input  logic signed [SUM_W-1:0]     x_in,
   output logic signed [ANG_OUT_W-1:0] angle
);

   // Pre stage: axis cases, scale by 256, fold left half-plane
   logic signed [DATA_W-1:0]    x_ff [CORDIC_STAGES+1];
   logic signed [DATA_W-1:0]    y_ff [CORDIC_STAGES+1];
   logic signed [ACC_W-1:0]     acc_ff [CORDIC_STAGES+1];
   logic                        spec_ff [CORDIC_STAGES+1];
   logic signed [ANG_OUT_W-1:0] sval_ff [CORDIC_STAGES+1];

   logic signed [DATA_W-1:0]    xs, ys, x0_in, y0_in;
   logic signed [ACC_W-1:0]     acc0_in;
   logic                        spec0_in;
   logic signed [ANG_OUT_W-1:0] sval0_in;

   always_comb begin
      xs       = DATA_W'(x_in) <<< 8;
      ys       = DATA_W'(y_in) <<< 8;
      x0_in    = xs;
      y0_in    = ys;
      acc0_in  = '0;
      spec0_in = 1'b0;
      sval0_in = '0;
      if (y_in == '0) begin
         spec0_in = 1'b1;
         sval0_in = (x_in < 0) ? ANG_HALF_TURN : '0;
      end else if (x_in == '0) begin
         spec0_in = 1'b1;
         sval0_in = (y_in > 0) ? ANG_QUARTER_P : ANG_QUARTER_N;
      end
      if (x_in < 0) begin
         if (y_in >= 0) begin
            x0_in   = ys;
            y0_in   = -xs;
            acc0_in = QUARTER_TURN;
         end else begin
            x0_in   = -ys;
            y0_in   = xs;
            acc0_in = -QUARTER_TURN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         acc_ff[0]  <= acc0_in;
         spec_ff[0] <= spec0_in;
         sval_ff[0] <= sval0_in;
      end
   end

   // Micro-rotation stages, one per table entry
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      logic signed [DATA_W-1:0] xsh, ysh, x_in_s, y_in_s;
      logic signed [ACC_W-1:0]  acc_in;

      always_comb begin
         xsh = x_ff[i] >>> i;
         ysh = y_ff[i] >>> i;
         if (y_ff[i] >= 0) begin
            x_in_s = x_ff[i] + ysh;
            y_in_s = y_ff[i] - xsh;
            acc_in = acc_ff[i] + atan_entry(5'(i));
         end else begin
            x_in_s = x_ff[i] - ysh;
            y_in_s = y_ff[i] + xsh;
            acc_in = acc_ff[i] - atan_entry(5'(i));
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]    <= x_in_s;
            y_ff[i+1]    <= y_in_s;
            acc_ff[i+1]  <= acc_in;
            spec_ff[i+1] <= spec_ff[i];
            sval_ff[i+1] <= sval_ff[i];
         end
      end
   end

   // Round half up to pi/2^15 and wrap to 16 bits
   logic signed [ACC_W-1:0]     acc_rnd;
   logic signed [ANG_OUT_W-1:0] angle_in, angle_ff;

   always_comb begin
      acc_rnd = acc_ff[CORDIC_STAGES] + ACC_W'(1 << (ROUND_LSB - 1));
      if (spec_ff[CORDIC_STAGES]) begin
         angle_in = sval_ff[CORDIC_STAGES];
      end else begin
         angle_in = acc_rnd[ROUND_LSB +: ANG_OUT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

>>> src/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// Channel  Dir  Width  Contents (low bit up)
// req      in   160    pos_x_in, pos_y_in, pos_z_in, quat_x, quat_y, quat_z, quat_w
// rsp      out  144    pos_x_out, pos_y_out, pos_z_out, angle_about_x, angle_about_y,
//                      angle_about_z
//
// One beat in per cycle while rsp is not stalled, one beat out per beat in. Stages:
// 5 product/sum stages, 31 square-root stages (one root bit each), 22 CORDIC stages.
// Synchronous reset clears the valid bits only.
// A stall on rsp freezes the whole pipeline; req_tready follows it.
module quaternion_to_euler_angles
   import qte_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,   // pos_x_in, pos_y_in, pos_z_in, quat_x..quat_w
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata    // pos_x/y/z_out, angle_about_x, _y, _z
);

   logic en;
   logic [TOTAL_LAT-1:0] vld_ff, vld_in;

   // Pipeline advances whenever the output beat is free or taken
   assign en         = !vld_ff[TOTAL_LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[TOTAL_LAT-1];

   assign vld_in = {vld_ff[TOTAL_LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Products, sums and radicand
   side_type side_p;
   logic [RAD_W-1:0] radicand;

   qte_prod u_prod (
      .clock    (clock),
      .en       (en),
      .pos_x    (req_tdata[31:0]),
      .pos_y    (req_tdata[63:32]),
      .pos_z    (req_tdata[95:64]),
      .qx       (req_tdata[111:96]),
      .qy       (req_tdata[127:112]),
      .qz       (req_tdata[143:128]),
      .qw       (req_tdata[159:144]),
      .side     (side_p),
      .radicand (radicand)
   );

   // Square root, side data delayed alongside
   logic [ROOT_W-1:0] root;
   side_type side_dly_ff [ISQ_LAT];

   qte_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .radicand (radicand),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         side_dly_ff[0] <= side_p;
         for (int k = 1; k < ISQ_LAT; k++) begin
            side_dly_ff[k] <= side_dly_ff[k-1];
         end
      end
   end

   side_type side_q;
   assign side_q = side_dly_ff[ISQ_LAT-1];

   // Three angle units in parallel
   logic signed [ANG_OUT_W-1:0] ang_x, ang_y_raw, ang_z, ang_y;

   qte_cordic u_cordic_x (
      .clock (clock),
      .en    (en),
      .y_in  (side_q.ax_y),
      .x_in  (side_q.ax_x),
      .angle (ang_x)
   );

   qte_cordic u_cordic_y (
      .clock (clock),
      .en    (en),
      .y_in  (SUM_W'(side_q.s)),
      .x_in  (SUM_W'({1'b0, root})),
      .angle (ang_y_raw)
   );

   qte_cordic u_cordic_z (
      .clock (clock),
      .en    (en),
      .y_in  (side_q.az_y),
      .x_in  (side_q.az_x),
      .angle (ang_z)
   );

   // Position rides along with the CORDIC
   logic [3*POS_W-1:0] pos_dly_ff [CORDIC_LAT];

   always_ff @(posedge clock) begin
      if (en) begin
         pos_dly_ff[0] <= {side_q.pos_z, side_q.pos_y, side_q.pos_x};
         for (int k = 1; k < CORDIC_LAT; k++) begin
            pos_dly_ff[k] <= pos_dly_ff[k-1];
         end
      end
   end

   // Saturate pitch to a quarter turn
   always_comb begin
      if (ang_y_raw > ANG_QUARTER_P) begin
         ang_y = ANG_QUARTER_P;
      end else if (ang_y_raw < ANG_QUARTER_N) begin
         ang_y = ANG_QUARTER_N;
      end else begin
         ang_y = ang_y_raw;
      end
   end

   assign rsp_tdata = {ang_z, ang_y, ang_x, pos_dly_ff[CORDIC_LAT-1]};

   // Checks
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[PROD_LAT+ISQ_LAT-1] |-> (root <= 31'h4000_0000))
      else $error("square root above one");

   a_pitch_near_quarter: assert property (@(posedge clock) disable iff (reset)
      vld_ff[TOTAL_LAT-1] |-> (ang_y_raw >= -16'sd16400 && ang_y_raw <= 16'sd16400))
      else $error("pitch angle outside a quarter turn before clamp");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
   import qte_pkg::*;

   typedef struct {
      logic signed [31:0] px, py, pz;
      logic signed [15:0] ang_x, ang_y, ang_z;
   } pose_angles_type;

   // Expected Euler outputs, oldest first
   class pose_scoreboard;
      pose_angles_type pending[$];
      int errors = 0;
      int checked = 0;

      // floor shift of a signed value
      static function longint fshr(longint v, int k);
         return v >>> k;
      endfunction

      static function longint root_floor(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // vectoring CORDIC atan2, pi/32768 units
      static function logic signed [15:0] vec_angle(longint y, longint x);
         longint acc, t, xs, ys;
         longint tbl[20];
         tbl = '{4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
                 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10};
         acc = 0;
         if (y == 0) return (x < 0) ? ANG_HALF_TURN : 16'sd0;
         if (x == 0) return (y > 0) ? ANG_QUARTER_P : ANG_QUARTER_N;
         x = x * 256;
         y = y * 256;
         if (x < 0) begin
            if (y >= 0) begin
               t = x; x = y; y = -t; acc = 8388608;
            end else begin
               t = x; x = -y; y = t; acc = -8388608;
            end
         end
         for (int i = 0; i < 20; i++) begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (y >= 0) begin
               x = x + ys; y = y - xs; acc = acc + tbl[i];
            end else begin
               x = x - ys; y = y + xs; acc = acc - tbl[i];
            end
         end
         acc = fshr(acc + 256, 9);
         return acc[15:0];
      endfunction

      function void note_pose(logic [159:0] d);
         pose_angles_type e;
         longint qx, qy, qz, qw, s, c, ay;
         qx = $signed(d[111:96]);
         qy = $signed(d[127:112]);
         qz = $signed(d[143:128]);
         qw = $signed(d[159:144]);
         e.px = d[31:0];
         e.py = d[63:32];
         e.pz = d[95:64];
         s = -2 * (qx * qz - qy * qw);
         if (s > 64'sd1073741824) s = 64'sd1073741824;
         if (s < -64'sd1073741824) s = -64'sd1073741824;
         c = root_floor((64'd1 << 60) - s * s);
         e.ang_x = vec_angle(2 * (qy * qz + qx * qw), qw*qw - qx*qx - qy*qy + qz*qz);
         ay = vec_angle(s, c);
         if (ay > 16384) ay = 16384;
         if (ay < -16384) ay = -16384;
         e.ang_y = ay[15:0];
         e.ang_z = vec_angle(2 * (qx * qy + qz * qw), qw*qw + qx*qx - qy*qy - qz*qz);
         pending.push_back(e);
      endfunction

      function void check_angles(logic [143:0] d);
         pose_angles_type e;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected rsp beat %h", d);
            return;
         end
         e = pending.pop_front();
         if (d !== {e.ang_z, e.ang_y, e.ang_x, e.pz, e.py, e.px}) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp pos %h %h %h ang %0d %0d %0d, got %h",
                        e.px, e.py, e.pz, e.ang_x, e.ang_y, e.ang_z, d);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [159:0] req_tdata;
   logic [143:0] rsp_tdata;
   pose_scoreboard sb;
   int idle_cycles;
   bit timed_out;

   quaternion_to_euler_angles uut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 70);
   endfunction

   function automatic logic [15:0] rand_part();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return $urandom_range(0, 1) ? 16'h4000 : 16'hc000;
         4: return 16'($urandom_range(0, 4000)) - 16'd2000;
         default: return 16'($urandom);
      endcase
   endfunction

   // send one pose beat, with a random gap ahead of it
   task automatic send_pose(logic [31:0] px, py, pz, logic [15:0] x, y, z, w);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {w, z, y, x, pz, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_pose(req_tdata);
   endtask

   task automatic send_quat(logic [15:0] x, y, z, w);
      send_pose($urandom, $urandom, $urandom, x, y, z, w);
   endtask

   // receiver stalls
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         rsp_tready <= 1'b1;
         @(posedge clock);
         if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (gap_len() + 1) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_angles(rsp_tdata);
   end

   // watchdog on accepted beats
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000 && !timed_out) begin
         timed_out = 1;
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int waited;
      sb = new();
      idle_cycles = 0;
      timed_out = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: zero, axes, extremes, non-unit, position extremes
      send_pose(32'h8000_0000, 32'h7fff_ffff, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0);
      send_pose(32'hffff_ffff, 32'h0, 32'h8000_0000, 16'h0, 16'h0, 16'h0, 16'h7fff);
      send_quat(16'h0, 16'h0, 16'h0, 16'h8000);
      send_quat(16'h7fff, 16'h0, 16'h0, 16'h0);
      send_quat(16'h0, 16'h7fff, 16'h0, 16'h0);
      send_quat(16'h0, 16'h0, 16'h7fff, 16'h0);
      send_quat(16'h8000, 16'h0, 16'h0, 16'h0);
      send_quat(16'h5a82, 16'h0, 16'h0, 16'h5a82);
      send_quat(16'h5a82, 16'h0, 16'h0, 16'ha57e);
      send_quat(16'h0, 16'h5a82, 16'h0, 16'h5a82);
      send_quat(16'h0, 16'ha57e, 16'h0, 16'h5a82);
      send_quat(16'h0, 16'h0, 16'h5a82, 16'h5a82);
      send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_quat(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
      send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_quat(16'h4000, 16'h4000, 16'h4000, 16'h4000);
      send_quat(16'h4000, 16'hc000, 16'h4000, 16'h4000);
      send_quat(16'h0, 16'h0, 16'h0, 16'h0001);
      send_quat(16'hffff, 16'h0, 16'h0, 16'h0);

      // hold off until the pipeline drains
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);

      // random poses, back-to-back bursts mixed with gaps
      for (int n = 0; n < 800; n++) begin
         if (n == 400) begin
            req_tvalid <= 1'b0;
            while (sb.pending.size() != 0) @(posedge clock);
         end
         send_quat(rand_part(), rand_part(), rand_part(), rand_part());
      end
      req_tvalid <= 1'b0;

      waited = 0;
      while (sb.pending.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (TOTAL_LAT + 10) @(posedge clock);
      $display("Checked %0d pose beats: axis, zero, extreme and non-unit quaternions,",
               sb.checked);
      $display("random poses under random sender gaps and receiver stalls.");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

>>> sim.f
src/qte_pkg.sv
src/qte_prod.sv
src/qte_isqrt.sv
src/qte_cordic.sv
src/quaternion_to_euler_angles.sv
test/tb.sv
